/* rtl/pspa_pkg.sv */
// Shared types, constants and helpers for the pitch-shifted phase accumulator.
`default_nettype none

package pspa_pkg;

  // Field widths of the channels.
  localparam int REQ_W      = 2;
  localparam int NOTE_W     = 24;
  localparam int OUT_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;

  // Register widths.
  localparam int SR_W     = 18;
  localparam int COARSE_W = 7;
  localparam int FINE_W   = 10;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_TICK    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_NOTE_ON = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COARSE_SHIFT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FINE_SHIFT   = 2'd2;

  localparam logic [SR_W-1:0]     SR_RESET     = 18'd48000;
  localparam logic [COARSE_W-1:0] COARSE_RESET = 7'd0;
  localparam logic [FINE_W-1:0]   FINE_RESET   = 10'd0;

  // Frequency formats: note in Q8, semitone ratio in Q16, product in Q24.
  localparam int FREQ_FRAC = 24;
  localparam int TBL_W     = 17;
  localparam int P1_W      = NOTE_W + TBL_W;
  // Octave index runs 0..11; index 6 means no octave shift.
  localparam int OCT_MAX   = 11;
  localparam int OCT_BIAS  = 6;
  localparam int F1_W      = P1_W + OCT_MAX - OCT_BIAS;
  // Step divisor is sample_rate scaled to Q24.
  localparam int D2_W      = SR_W + FREQ_FRAC;

  // 2^(k/12) in Q16, rounded to nearest.
  localparam logic [TBL_W-1:0] SEMI_Q16 [12] = '{
    17'd65536,  17'd69433,  17'd73562,  17'd77936,
    17'd82570,  17'd87480,  17'd92682,  17'd98193,
    17'd104032, 17'd110218, 17'd116772, 17'd123715
  };

  typedef struct packed {
    logic [3:0] oct;   // octave index, 0..11
    logic [3:0] semi;  // semitone within the octave, 0..11
  } oct_split_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_DIV1,
    ST_DIV2,
    ST_DONE
  } state_t;

  // Split a signed semitone offset into octave and semitone (floor division
  // by 12 through a reciprocal multiply, exact over the biased range 8..135).
  function automatic oct_split_t split_coarse(logic [COARSE_W-1:0] c);
    logic [7:0]  b;
    logic [15:0] m;
    oct_split_t  r;
    b      = {c[COARSE_W-1], c} + 8'd72;
    m      = 16'(b) * 16'd171;
    r.oct  = m[14:11];
    r.semi = 4'(b - 8'(r.oct) * 8'd12);
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/pspa_ifs.sv */
// Channel interfaces: request, response and configuration write.
`default_nettype none

interface pspa_req_if;
  import pspa_pkg::*;
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [NOTE_W-1:0] note_freq;
  modport source (output valid, req_type, note_freq, input ready);
  modport sink   (input valid, req_type, note_freq, output ready);
endinterface

interface pspa_rsp_if;
  import pspa_pkg::*;
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] phase;
  logic [OUT_W-1:0] phase_step;
  logic             silent;
  modport source (output valid, phase, phase_step, silent, input ready);
  modport sink   (input valid, phase, phase_step, silent, output ready);
endinterface

interface pspa_cfg_if;
  import pspa_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/pspa_smul.sv */
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
`default_nettype none

module pspa_smul #(
  parameter int AW = 24,
  parameter int BW = 17
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] p,
  output logic             done
);

  localparam int CW = $clog2(BW + 1);

  logic [AW-1:0] a_hold;
  logic [CW-1:0] cnt;
  logic [AW:0]   sum;

  // Add the multiplicand to the upper half when the current bit is set.
  assign sum = {1'b0, p[AW+BW-1:BW]} + (p[0] ? {1'b0, a_hold} : '0);

  // Count the steps and flag the cycle the product is final.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CW'(BW);
      end else if (cnt != '0) begin
        cnt  <= cnt - 1'b1;
        done <= (cnt == CW'(1));
      end
    end
  end

  // Load operands, then shift the partial product right each step.
  always_ff @(posedge clk) begin
    if (start) begin
      a_hold <= a;
      p      <= {{AW{1'b0}}, b};
    end else if (cnt != '0) begin
      p <= {sum, p[BW-1:1]};
    end
  end

endmodule

`default_nettype wire

/* rtl/pspa_sdiv.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none

module pspa_sdiv #(
  parameter int NW = 32,
  parameter int DW = 42
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] rem_init,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo,
  output logic          done
);

  localparam int CW = $clog2(NW + 1);

  logic [CW-1:0] cnt;
  logic [DW-1:0] r;
  logic [DW-1:0] d;
  logic [NW-1:0] n;
  logic [DW:0]   t;
  logic [DW:0]   diff;
  logic          ge;

  // Bring down the next dividend bit and trial-subtract the divisor.
  assign t    = {r, n[NW-1]};
  assign ge   = (t >= {1'b0, d});
  assign diff = t - {1'b0, d};

  // Count the steps and flag the cycle the quotient is final.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CW'(NW);
      end else if (cnt != '0) begin
        cnt  <= cnt - 1'b1;
        done <= (cnt == CW'(1));
      end
    end
  end

  // Load operands, then shift in one quotient bit per step.
  always_ff @(posedge clk) begin
    if (start) begin
      r <= rem_init;
      d <= den;
      n <= num;
    end else if (cnt != '0) begin
      r   <= ge ? diff[DW-1:0] : t[DW-1:0];
      n   <= {n[NW-2:0], 1'b0};
      quo <= {quo[NW-2:0], ge};
    end
  end

endmodule

`default_nettype wire

/* rtl/pitch_shifted_phase_accumulator_top.sv */
// Top level of the pitch-shifted oscillator phase accumulator.
//
//   channel | role   | transfer carries
//   --------+--------+--------------------------------------------
//   req     | sink   | req_type, note_freq
//   rsp     | source | phase, phase_step, silent
//   cfg     | sink   | index, data (sample_rate, coarse_shift, fine_shift)
//
// A tick or note-on runs four bit-serial units in turn: the semitone multiply,
// the fine-ratio multiply, the division by FINE_STEPS and the division by the
// sample rate (skipped on saturation), each unit handing off to the next. The
// result becomes valid and req ready returns in the same cycle. A clear or an
// unused request skips the units and goes straight to the final step. Reset is
// synchronous; no clearing pass. A result still waiting on rsp holds the next
// one at its final step; no new request is taken until that result is loaded.
`default_nettype none

module pitch_shifted_phase_accumulator_top #(
  parameter int FINE_STEPS = 1000,
  parameter int PHASE_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  pspa_req_if.sink      req,
  pspa_rsp_if.source    rsp,
  pspa_cfg_if.sink      cfg
);

  import pspa_pkg::*;

  localparam int PB  = PHASE_BITS;
  localparam int MW  = $clog2(FINE_STEPS + 1024);
  localparam int XW  = F1_W + MW;
  localparam int FSW = $clog2(FINE_STEPS + 1);
  localparam logic [FSW-1:0] FS_DEN = FSW'(FINE_STEPS);

  // Configuration registers.
  logic [SR_W-1:0]     sample_rate;
  logic [COARSE_W-1:0] coarse_shift;
  logic [FINE_W-1:0]   fine_shift;

  // Oscillator state and control.
  state_t           state, state_next;
  logic [REQ_W-1:0] kind;
  logic [PB-1:0]    phase_acc, phase_next;
  logic [PB-1:0]    step_reg, step_next;
  logic [PB-1:0]    step_calc;
  logic             sat, sat_next;
  logic             rsp_valid;
  logic             out_load;
  logic             accept;

  // Datapath between the serial units.
  oct_split_t                    split;
  logic [TBL_W-1:0]              ratio;
  logic [P1_W-1:0]               p1;
  logic [P1_W+OCT_MAX-1:0]       p1_shifted;
  logic [F1_W-1:0]               f1;
  logic [MW-1:0]                 fine_mult;
  logic [XW-1:0]                 p2;
  logic [XW-1:0]                 f2;
  logic [PB-1:0]                 quo2;
  logic                          over;
  logic                          start1, start2, start3, start4;
  logic                          mul1_done, mul2_done, div1_done, div2_done;
  logic [PB+OUT_W-1:0]           phase_ext;
  logic [PB+OUT_W-1:0]           step_ext;

  assign cfg.ready = 1'b1;
  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;

  // Write configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate  <= SR_RESET;
      coarse_shift <= COARSE_RESET;
      fine_shift   <= FINE_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_SAMPLE_RATE:  sample_rate  <= cfg.data[SR_W-1:0];
        CFG_COARSE_SHIFT: coarse_shift <= cfg.data[COARSE_W-1:0];
        CFG_FINE_SHIFT:   fine_shift   <= cfg.data[FINE_W-1:0];
        default: ;
      endcase
    end
  end

  // Semitone ratio and octave shift from the coarse offset.
  assign split      = split_coarse(coarse_shift);
  assign ratio      = SEMI_Q16[split.semi];
  assign p1_shifted = {{OCT_MAX{1'b0}}, p1} << split.oct;
  assign f1         = p1_shifted[P1_W+OCT_MAX-1:OCT_BIAS];
  assign fine_mult  = MW'(FINE_STEPS) + MW'(fine_shift);

  // Saturate when the shifted frequency reaches the sample rate.
  assign over      = (f2[XW-1:FREQ_FRAC] >= (XW-FREQ_FRAC)'(sample_rate));
  assign step_calc = sat ? {PB{1'b1}} : quo2;

  pspa_smul #(.AW(NOTE_W), .BW(TBL_W)) u_mul_semi (
    .clk   (clk),
    .rst   (rst),
    .start (start1),
    .a     (req.note_freq),
    .b     (ratio),
    .p     (p1),
    .done  (mul1_done)
  );

  pspa_smul #(.AW(F1_W), .BW(MW)) u_mul_fine (
    .clk   (clk),
    .rst   (rst),
    .start (start2),
    .a     (f1),
    .b     (fine_mult),
    .p     (p2),
    .done  (mul2_done)
  );

  pspa_sdiv #(.NW(XW), .DW(FSW)) u_div_fine (
    .clk      (clk),
    .rst      (rst),
    .start    (start3),
    .rem_init ('0),
    .num      (p2),
    .den      (FS_DEN),
    .quo      (f2),
    .done     (div1_done)
  );

  pspa_sdiv #(.NW(PB), .DW(D2_W)) u_div_rate (
    .clk      (clk),
    .rst      (rst),
    .start    (start4),
    .rem_init (f2[D2_W-1:0]),
    .num      ('0),
    .den      ({sample_rate, {FREQ_FRAC{1'b0}}}),
    .quo      (quo2),
    .done     (div2_done)
  );

  // Sequence the units and commit the result.
  always_comb begin
    state_next = state;
    sat_next   = sat;
    phase_next = phase_acc;
    step_next  = step_reg;
    start1     = 1'b0;
    start2     = 1'b0;
    start3     = 1'b0;
    start4     = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          if (req.req_type == REQ_TICK || req.req_type == REQ_NOTE_ON) begin
            start1     = 1'b1;
            state_next = ST_MUL1;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_MUL1: begin
        if (mul1_done) begin
          start2     = 1'b1;
          state_next = ST_MUL2;
        end
      end
      ST_MUL2: begin
        if (mul2_done) begin
          start3     = 1'b1;
          state_next = ST_DIV1;
        end
      end
      ST_DIV1: begin
        if (div1_done) begin
          sat_next = over;
          if (over) begin
            state_next = ST_DONE;
          end else begin
            start4     = 1'b1;
            state_next = ST_DIV2;
          end
        end
      end
      ST_DIV2: begin
        if (div2_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!rsp_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
          case (kind)
            REQ_TICK: begin
              step_next  = step_calc;
              phase_next = phase_acc + step_calc;
            end
            REQ_NOTE_ON: begin
              step_next  = step_calc;
              phase_next = '0;
            end
            REQ_CLEAR: begin
              step_next = '0;
            end
            default: ;
          endcase
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Hold state, oscillator registers and response valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase_acc <= '0;
      step_reg  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      phase_acc <= phase_next;
      step_reg  <= step_next;
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Latch the request kind and the saturation flag.
  always_ff @(posedge clk) begin
    sat <= sat_next;
    if (accept) begin
      kind <= req.req_type;
    end
  end

  // Present the state; it changes only when a new result is loaded.
  assign phase_ext      = {{OUT_W{1'b0}}, phase_acc};
  assign step_ext       = {{OUT_W{1'b0}}, step_reg};
  assign rsp.valid      = rsp_valid;
  assign rsp.phase      = phase_ext[OUT_W-1:0];
  assign rsp.phase_step = step_ext[OUT_W-1:0];
  assign rsp.silent     = (step_reg == '0);

endmodule

`default_nettype wire

/* rtl/pspa_chk.sv */
// Port-level checks for the phase accumulator, bound to the top level.
`default_nettype none

module pspa_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic [pspa_pkg::REQ_W-1:0]    req_type,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [pspa_pkg::OUT_W-1:0]    rsp_phase,
  input logic [pspa_pkg::OUT_W-1:0]    rsp_phase_step,
  input logic                          rsp_silent
);

  import pspa_pkg::*;

  // A nonzero step is never reported as silent.
  a_silent_step: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_phase_step != '0) |-> !rsp_silent)
    else $error("silent set with a nonzero phase step");

  // A stalled response holds its payload.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_phase)
      && $stable(rsp_phase_step) && $stable(rsp_silent))
    else $error("response changed while stalled");

  // One request at a time: ready drops after every transfer in.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in progress");

  // A clear taken with the response side empty reports a zero step.
  a_clear_silent: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_type == REQ_CLEAR) && !rsp_valid
      |=> ##1 rsp_valid && rsp_silent && (rsp_phase_step == '0))
    else $error("clear did not report a zero step");

endmodule

bind pitch_shifted_phase_accumulator_top pspa_chk u_pspa_chk (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .req_type       (req.req_type),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_phase      (rsp.phase),
  .rsp_phase_step (rsp.phase_step),
  .rsp_silent     (rsp.silent)
);

`default_nettype wire

/* tb/tb_top.sv */
// Testbench for the pitch-shifted phase accumulator: directed table, random phases, model check.
`timescale 1ns / 1ps

module tb_top;
  import pspa_pkg::*;

  localparam logic [REQ_W-1:0]     REQ_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int PHASE_COUNT     = 14;
  localparam int ITEMS_PER_PHASE = 70;
  localparam int DIR_ROWS        = 21;
  localparam int TAIL_CYCLES     = 140;
  localparam int PRINT_CAP       = 100;

  typedef struct packed {
    logic [OUT_W-1:0] phase;
    logic [OUT_W-1:0] phase_step;
    logic             silent;
  } osc_out_t;

  typedef struct packed {
    logic [REQ_W-1:0]  kind;
    logic [NOTE_W-1:0] note;
    logic              pinned;
    osc_out_t          out;
  } row_t;

  logic clk;
  logic rst;

  pspa_req_if req_ch ();
  pspa_rsp_if rsp_ch ();
  pspa_cfg_if cfg_ch ();

  pitch_shifted_phase_accumulator_top i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // Model state and configuration
  logic [SR_W-1:0]     rate_r   = SR_RESET;
  logic [COARSE_W-1:0] coarse_r = COARSE_RESET;
  logic [FINE_W-1:0]   fine_r   = FINE_RESET;
  logic [OUT_W-1:0]    osc_phase = '0;
  logic [OUT_W-1:0]    osc_step  = '0;

  osc_out_t due_outputs [$];
  int       err_count = 0;
  bit       req_quiet = 1'b0;
  bit       rsp_quiet = 1'b0;
  logic     pin_on    = 1'b0;
  osc_out_t pin_out   = '0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard limit on run time
  initial begin
    #3000000;
    $display("tb_top: done, errors");
    $finish;
  end

  task automatic flag_error(input string msg);
    if (err_count < PRINT_CAP)
      $display("MISMATCH @%0t: %s", $time, msg);
    err_count++;
  endtask

  function automatic logic [16:0] semitone_q16(input int k);
    case (k)
      0:       return 17'd65536;
      1:       return 17'd69433;
      2:       return 17'd73562;
      3:       return 17'd77936;
      4:       return 17'd82570;
      5:       return 17'd87480;
      6:       return 17'd92682;
      7:       return 17'd98193;
      8:       return 17'd104032;
      9:       return 17'd110218;
      10:      return 17'd116772;
      default: return 17'd123715;
    endcase
  endfunction

  // Note frequency after coarse and fine pitch shift, Q24 hertz
  function automatic logic [63:0] pitch_freq(input logic [NOTE_W-1:0] note);
    int          semis;
    int          biased;
    int          oct;
    logic [63:0] f1;
    semis  = $signed(coarse_r);
    biased = semis + 72;
    oct    = biased / 12 - 6;
    f1     = 64'(note) * 64'(semitone_q16(biased % 12));
    if (oct >= 0)
      f1 = f1 << oct;
    else
      f1 = f1 >> (-oct);
    return f1 + (f1 * 64'(fine_r)) / 64'd1000;
  endfunction

  // Per-sample increment in turns times 2^32, saturated
  function automatic logic [OUT_W-1:0] step_of(input logic [63:0] f2);
    logic [63:0] full_scale;
    full_scale = 64'(rate_r) << 24;
    if (f2 >= full_scale)
      return '1;
    return 32'((f2 << 8) / 64'(rate_r));
  endfunction

  // Apply one request to the model and return what the block should report
  function automatic osc_out_t advance_osc(input logic [REQ_W-1:0] kind,
                                           input logic [NOTE_W-1:0] note);
    osc_out_t o;
    case (kind)
      REQ_TICK: begin
        osc_step  = step_of(pitch_freq(note));
        osc_phase = osc_phase + osc_step;
      end
      REQ_NOTE_ON: begin
        osc_step  = step_of(pitch_freq(note));
        osc_phase = '0;
      end
      REQ_CLEAR: begin
        osc_step = '0;
      end
      default: ;
    endcase
    o.phase      = osc_phase;
    o.phase_step = osc_step;
    o.silent     = (osc_step == '0);
    return o;
  endfunction

  // Check results, track register writes, predict accepted requests
  always @(posedge clk) begin
    osc_out_t got;
    osc_out_t want;
    osc_out_t pred;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got = '{rsp_ch.phase, rsp_ch.phase_step, rsp_ch.silent};
      if (due_outputs.size() == 0) begin
        flag_error($sformatf("unexpected result phase=%h step=%h", got.phase,
                             got.phase_step));
      end else begin
        want = due_outputs.pop_front();
        if (got.phase !== want.phase)
          flag_error($sformatf("phase %h, want %h", got.phase, want.phase));
        if (got.phase_step !== want.phase_step)
          flag_error($sformatf("phase_step %h, want %h", got.phase_step,
                               want.phase_step));
        if (got.silent !== want.silent)
          flag_error($sformatf("silent %b, want %b", got.silent, want.silent));
      end
    end
    if (!rst && cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        CFG_SAMPLE_RATE:  rate_r   = cfg_ch.data[SR_W-1:0];
        CFG_COARSE_SHIFT: coarse_r = cfg_ch.data[COARSE_W-1:0];
        CFG_FINE_SHIFT:   fine_r   = cfg_ch.data[FINE_W-1:0];
        default: ;
      endcase
    end
    if (!rst && req_ch.valid && req_ch.ready) begin
      pred = advance_osc(req_ch.req_type, req_ch.note_freq);
      due_outputs.push_back(pin_on ? pin_out : pred);
    end
  end

  // Response side: stall a random number of cycles before each transfer
  initial begin
    int n;
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      n = rsp_quiet ? 0 : $urandom_range(0, 4);
      repeat (n) begin
        rsp_ch.ready <= 1'b0;
        @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
      @(negedge clk);
    end
  end

  // Drive one request after a random gap and hold it until the transfer
  task automatic send_item(input logic [REQ_W-1:0] kind, input logic [NOTE_W-1:0] note,
                           input logic pinned, input osc_out_t out);
    int n;
    n = req_quiet ? 0 : $urandom_range(0, 4);
    repeat (n) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
    end
    @(negedge clk);
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= kind;
    req_ch.note_freq <= note;
    pin_on           <= pinned;
    pin_out          <= out;
    do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic drain();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (due_outputs.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic row_t row(input logic [REQ_W-1:0] kind, input logic [NOTE_W-1:0] note,
                               input logic pinned, input logic [OUT_W-1:0] ph,
                               input logic [OUT_W-1:0] st, input logic sil);
    row_t r;
    r.kind           = kind;
    r.note           = note;
    r.pinned         = pinned;
    r.out.phase      = ph;
    r.out.phase_step = st;
    r.out.silent     = sil;
    return r;
  endfunction

  // Mostly short notes, some zero and full scale, every bit reachable
  function automatic logic [NOTE_W-1:0] rand_note();
    int c;
    c = $urandom_range(0, 7);
    if (c == 0)
      return '0;
    if (c == 1)
      return '1;
    return NOTE_W'($urandom) >> $urandom_range(0, NOTE_W - 1);
  endfunction

  // Note-on followed by runs of ticks on the same note, with clears and noise
  task automatic run_random(input int count);
    logic [NOTE_W-1:0] held_note;
    logic [NOTE_W-1:0] note;
    logic [REQ_W-1:0]  kind;
    int                r;
    held_note = rand_note();
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 9);
      if (r < 6)
        kind = REQ_TICK;
      else if (r < 8)
        kind = REQ_NOTE_ON;
      else if (r == 8)
        kind = REQ_CLEAR;
      else
        kind = REQ_UNUSED;
      if (kind == REQ_NOTE_ON || $urandom_range(0, 4) == 0)
        held_note = rand_note();
      note = held_note;
      if (kind == REQ_CLEAR || kind == REQ_UNUSED)
        note = NOTE_W'($urandom);
      send_item(kind, note, 1'b0, '0);
    end
  endtask

  // Main sequence
  initial begin
    row_t                  dir_rows [DIR_ROWS];
    logic [SR_W-1:0]       sr_val;
    logic [COARSE_W-1:0]   coarse_val;
    logic [FINE_W-1:0]     fine_val;
    logic [CFG_DATA_W-1:0] junk;

    rst              = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.req_type  = REQ_TICK;
    req_ch.note_freq = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = CFG_SAMPLE_RATE;
    cfg_ch.data      = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Reset configuration: 48 kHz, no shift
    dir_rows[0]  = row(REQ_TICK,    24'h000000, 1, 32'h0,        32'h0,        1'b1);
    dir_rows[1]  = row(REQ_NOTE_ON, 24'h000000, 1, 32'h0,        32'h0,        1'b1);
    dir_rows[2]  = row(REQ_UNUSED,  24'hFFFFFF, 1, 32'h0,        32'h0,        1'b1);
    dir_rows[3]  = row(REQ_CLEAR,   24'hFFFFFF, 1, 32'h0,        32'h0,        1'b1);
    dir_rows[4]  = row(REQ_NOTE_ON, 24'hFFFFFF, 1, 32'h0,        32'hFFFFFFFF, 1'b0);
    dir_rows[5]  = row(REQ_TICK,    24'hFFFFFF, 1, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0);
    dir_rows[6]  = row(REQ_TICK,    24'hFFFFFF, 1, 32'hFFFFFFFE, 32'hFFFFFFFF, 1'b0);
    dir_rows[7]  = row(REQ_CLEAR,   24'h000000, 1, 32'hFFFFFFFE, 32'h0,        1'b1);
    dir_rows[8]  = row(REQ_UNUSED,  24'h123456, 1, 32'hFFFFFFFE, 32'h0,        1'b1);
    dir_rows[9]  = row(REQ_NOTE_ON, 24'h01B800, 0, '0, '0, 1'b0);
    dir_rows[10] = row(REQ_TICK,    24'h01B800, 0, '0, '0, 1'b0);
    dir_rows[11] = row(REQ_TICK,    24'h01B800, 0, '0, '0, 1'b0);
    dir_rows[12] = row(REQ_TICK,    24'h000001, 0, '0, '0, 1'b0);
    dir_rows[13] = row(REQ_TICK,    24'h800000, 0, '0, '0, 1'b0);
    dir_rows[14] = row(REQ_TICK,    24'h555555, 0, '0, '0, 1'b0);
    dir_rows[15] = row(REQ_TICK,    24'hAAAAAA, 0, '0, '0, 1'b0);
    dir_rows[16] = row(REQ_CLEAR,   24'h000000, 0, '0, '0, 1'b0);
    dir_rows[17] = row(REQ_TICK,    24'h000000, 0, '0, '0, 1'b0);
    dir_rows[18] = row(REQ_NOTE_ON, 24'h7FFFFF, 0, '0, '0, 1'b0);
    // Exactly at and just below the saturation point
    dir_rows[19] = row(REQ_TICK,    24'hBB8000, 0, '0, '0, 1'b0);
    dir_rows[20] = row(REQ_TICK,    24'hBB7FFF, 0, '0, '0, 1'b0);

    for (int i = 0; i < DIR_ROWS; i++)
      send_item(dir_rows[i].kind, dir_rows[i].note, dir_rows[i].pinned, dir_rows[i].out);
    drain();

    // Random phases, each under its own register setting
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0: begin sr_val = 18'd0;      coarse_val = 7'sd0;   fine_val = 10'd0;    end
        1: begin sr_val = 18'd8000;   coarse_val = -7'sd48; fine_val = 10'd0;    end
        2: begin sr_val = 18'd192000; coarse_val = 7'sd48;  fine_val = 10'd1000; end
        3: begin sr_val = 18'h3FFFF;  coarse_val = 7'sd63;  fine_val = 10'd1023; end
        4: begin sr_val = 18'd1;      coarse_val = -7'sd64; fine_val = 10'd1023; end
        5: begin sr_val = 18'd44100;  coarse_val = 7'sd0;   fine_val = 10'd1000; end
        default: begin
          sr_val     = 18'($urandom_range(8000, 192000));
          coarse_val = 7'($urandom);
          fine_val   = 10'($urandom_range(0, 1023));
        end
      endcase
      // Upper data bits beyond each register are don't-care; drive them randomly
      junk = 18'($urandom);
      write_reg(CFG_SAMPLE_RATE, sr_val);
      write_reg(CFG_COARSE_SHIFT, {junk[CFG_DATA_W-1:COARSE_W], coarse_val});
      write_reg(CFG_FINE_SHIFT, {junk[CFG_DATA_W-1:FINE_W], fine_val});
      if (p == 0)
        write_reg(CFG_UNUSED, junk);
      req_quiet = p[0];
      rsp_quiet = p[1];
      run_random(ITEMS_PER_PHASE);
      drain();
    end

    // Hold for late strays before the verdict
    repeat (TAIL_CYCLES) @(negedge clk);
    if (err_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
